/* src/script_token_lexer_unit_assert.svh */
// assertion macros shared by the script token lexer modules
`ifndef SCRIPT_TOKEN_LEXER_UNIT_ASSERT_SVH
`define SCRIPT_TOKEN_LEXER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define STLX_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define STLX_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// condition never holds
`define STLX_ASSERT_NEVER(lbl, clk, rstn, bad, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(bad)) \
        else $error(msg);

`endif

/* src/stlx_pkg.sv */
// shared types and constants of the script token lexer
package stlx_pkg;

    localparam int BYTE_W          = 8;
    localparam int MAX_TOKEN_CHARS = 511;
    localparam int LEN_W           = $clog2(MAX_TOKEN_CHARS + 1);
    localparam int RES_MAX         = 4;
    localparam int RES_CNT_W       = $clog2(RES_MAX + 1);
    localparam int RES_IDX_W       = $clog2(RES_MAX);
    localparam int QUEUE_DEPTH     = 4;

    typedef enum logic [2:0] {
        LEX_IDLE   = 3'd0,
        LEX_IDENT  = 3'd1,
        LEX_STRING = 3'd2,
        LEX_NUMBER = 3'd3,
        LEX_OPER   = 3'd4,
        LEX_SINGLE = 3'd5
    } lex_mode_t;

    typedef enum logic [2:0] {
        KIND_IDENT  = 3'd0,
        KIND_STRING = 3'd1,
        KIND_NUMBER = 3'd2,
        KIND_OPER   = 3'd3,
        KIND_SINGLE = 3'd4
    } token_kind_t;

    typedef struct packed {
        lex_mode_t               mode;
        logic [LEN_W-1:0]        len;
        logic                    esc;
        logic                    comment;
        logic                    slash;
        logic [BYTE_W-1:0]       oper_char;
    } stlx_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        token_kind_t       kind;
        logic              start;
        logic              tend;
    } stlx_result_t;

    typedef struct packed {
        stlx_result_t [RES_MAX-1:0] res;
        logic [RES_CNT_W-1:0]       cnt;
    } stlx_bundle_t;

endpackage

/* src/stlx_front.sv */
// front end: lexer state and per-byte classification into result bundles
`include "script_token_lexer_unit_assert.svh"

module stlx_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           in_char,
    input  logic                 end_of_data,
    input  logic                 q_full,
    output logic                 q_wr,
    output stlx_pkg::stlx_bundle_t q_wr_data
);

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5a;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7a;
    localparam logic [7:0] CH_BAR    = 8'h7c;

    localparam int LEN_W = stlx_pkg::LEN_W;
    localparam int CNT_W = stlx_pkg::RES_CNT_W;
    localparam int IDX_W = stlx_pkg::RES_IDX_W;

    typedef struct packed {
        stlx_pkg::stlx_state_t  st;
        stlx_pkg::stlx_bundle_t bd;
    } work_t;

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NL;
    endfunction

    function automatic logic is_oper(logic [7:0] c);
        return c == CH_EQ || c == CH_LT || c == CH_GT || c == CH_MINUS ||
               c == CH_PLUS || c == CH_BANG || c == CH_AMP || c == CH_BAR;
    endfunction

    function automatic stlx_pkg::token_kind_t kind_of(stlx_pkg::lex_mode_t m);
        stlx_pkg::token_kind_t k;
        case (m)
            stlx_pkg::LEX_IDENT:  k = stlx_pkg::KIND_IDENT;
            stlx_pkg::LEX_STRING: k = stlx_pkg::KIND_STRING;
            stlx_pkg::LEX_NUMBER: k = stlx_pkg::KIND_NUMBER;
            stlx_pkg::LEX_OPER:   k = stlx_pkg::KIND_OPER;
            stlx_pkg::LEX_SINGLE: k = stlx_pkg::KIND_SINGLE;
            default:              k = stlx_pkg::KIND_IDENT;
        endcase
        return k;
    endfunction

    function automatic work_t push_res(work_t w, logic [7:0] c, logic s, logic e);
        work_t r;
        r = w;
        if (w.bd.cnt < CNT_W'(stlx_pkg::RES_MAX)) begin
            r.bd.res[w.bd.cnt[IDX_W-1:0]] = '{ch: c, kind: kind_of(w.st.mode),
                                              start: s, tend: e};
            r.bd.cnt = w.bd.cnt + CNT_W'(1);
        end
        return r;
    endfunction

    // bytes past the length limit are swallowed
    function automatic work_t emit_byte(work_t w, logic [7:0] c);
        work_t r;
        r = w;
        if (w.st.len < LEN_W'(stlx_pkg::MAX_TOKEN_CHARS)) begin
            r = push_res(w, c, w.st.len == '0, 1'b0);
            r.st.len = w.st.len + LEN_W'(1);
        end
        return r;
    endfunction

    function automatic work_t begin_token(work_t w, stlx_pkg::lex_mode_t m, logic [7:0] c);
        work_t r;
        r = w;
        r.st.mode = m;
        r.st.len = '0;
        r = emit_byte(r, c);
        return r;
    endfunction

    function automatic work_t close_token(work_t w);
        work_t r;
        r = w;
        if (w.st.mode != stlx_pkg::LEX_IDLE) begin
            r = push_res(r, 8'h00, 1'b0, 1'b1);
        end
        r.st.mode = stlx_pkg::LEX_IDLE;
        r.st.len = '0;
        r.st.esc = 1'b0;
        return r;
    endfunction

    function automatic work_t feed(work_t w, logic [7:0] c);
        work_t r;
        logic  cont;
        r = w;
        cont = 1'b1;
        case (w.st.mode)
            stlx_pkg::LEX_IDENT: begin
                if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
                    r = emit_byte(r, c);
                    cont = 1'b0;
                end else begin
                    r = close_token(r);
                end
            end
            stlx_pkg::LEX_NUMBER: begin
                if (is_digit(c) || c == CH_DOT) begin
                    r = emit_byte(r, c);
                    cont = 1'b0;
                end else begin
                    r = close_token(r);
                end
            end
            stlx_pkg::LEX_STRING: begin
                cont = 1'b0;
                if (w.st.esc) begin
                    r.st.esc = 1'b0;
                    r = emit_byte(r, c);
                end else if (c == CH_BSLASH) begin
                    r.st.esc = 1'b1;
                    r = emit_byte(r, c);
                end else begin
                    r = emit_byte(r, c);
                    if (c == CH_QUOTE) begin
                        r = close_token(r);
                    end
                end
            end
            stlx_pkg::LEX_IDLE: begin
                cont = 1'b1;
            end
            default: begin
                r = close_token(r);
            end
        endcase
        if (cont && !is_space(c)) begin
            if (is_alpha(c)) begin
                r = begin_token(r, stlx_pkg::LEX_IDENT, c);
            end else if (c == CH_QUOTE) begin
                r.st.esc = 1'b0;
                r = begin_token(r, stlx_pkg::LEX_STRING, c);
            end else if (is_digit(c)) begin
                r = begin_token(r, stlx_pkg::LEX_NUMBER, c);
            end else if (is_oper(c)) begin
                r = begin_token(r, stlx_pkg::LEX_OPER, c);
                r.st.oper_char = c;
            end else begin
                r = begin_token(r, stlx_pkg::LEX_SINGLE, c);
            end
        end
        return r;
    endfunction

    function automatic work_t lex_step(stlx_pkg::stlx_state_t st, logic [7:0] c, logic eod);
        work_t      w;
        logic [7:0] f;
        logic       dbl;
        logic       merge;
        w.st = st;
        w.bd = '0;
        f = st.oper_char;
        dbl = f == CH_EQ || f == CH_AMP || f == CH_BAR || f == CH_PLUS || f == CH_MINUS;
        merge = 1'b0;
        if (eod) begin
            w.st.comment = 1'b0;
            if (w.st.slash) begin
                w.st.slash = 1'b0;
                w = feed(w, CH_SLASH);
            end
            w = close_token(w);
            w.st.slash = 1'b0;
        end else if (w.st.comment) begin
            if (c == CH_NL) begin
                w.st.comment = 1'b0;
                w = feed(w, c);
            end
        end else if (w.st.slash) begin
            w.st.slash = 1'b0;
            if (c == CH_SLASH) begin
                w.st.comment = 1'b1;
            end else begin
                w = feed(w, CH_SLASH);
                w = feed(w, c);
            end
        end else begin
            if (w.st.mode == stlx_pkg::LEX_OPER) begin
                merge = dbl ? (c == f) : (c == CH_EQ);
                if (merge) begin
                    w = emit_byte(w, c);
                end
                w = close_token(w);
            end
            if (!merge) begin
                if (c == CH_SLASH) begin
                    w.st.slash = 1'b1;
                end else begin
                    w = feed(w, c);
                end
            end
        end
        return w;
    endfunction

    stlx_pkg::stlx_state_t state_reg;
    stlx_pkg::stlx_state_t state_next;
    work_t                 step;
    logic                  accept;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign step      = lex_step(state_reg, in_char, end_of_data);
    assign q_wr      = accept && (step.bd.cnt != '0);
    assign q_wr_data = step.bd;

    always_comb begin
        state_next = state_reg;
        if (accept) begin
            state_next = step.st;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    `STLX_ASSERT_IMP(a_idle_len_zero, aclk, aresetn, state_reg.mode == stlx_pkg::LEX_IDLE, state_reg.len == '0, "idle lexer holds a nonzero token length")
    `STLX_ASSERT_NEVER(a_hold_exclusive, aclk, aresetn, state_reg.slash && (state_reg.comment || state_reg.mode == stlx_pkg::LEX_OPER), "held slash overlaps comment or operator")

endmodule

/* src/stlx_queue.sv */
// short bundle queue between front and back end
`include "script_token_lexer_unit_assert.svh"

module stlx_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   wr_en,
    input  stlx_pkg::stlx_bundle_t wr_data,
    output logic                   full,
    input  logic                   rd_en,
    output logic                   rd_valid,
    output stlx_pkg::stlx_bundle_t rd_data
);

    localparam int DEPTH = stlx_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QC_W  = $clog2(DEPTH + 1);

    stlx_pkg::stlx_bundle_t mem_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [QC_W-1:0]        count_reg;
    logic [QC_W-1:0]        count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full     = count_reg == QC_W'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_en ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd_en ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + QC_W'(1);
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - QC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `STLX_ASSERT_NXT(a_fill_grows, aclk, aresetn, wr_en && !rd_en, count_reg == $past(count_reg) + QC_W'(1), "queue fill did not grow on write")

endmodule

/* src/stlx_back.sv */
// back end: plays out a bundle one result per cycle while m_tready is high, on the output register
`include "script_token_lexer_unit_assert.svh"

module stlx_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  stlx_pkg::stlx_bundle_t q_data,
    output logic                   q_rd,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output stlx_pkg::stlx_result_t m_res
);

    localparam int CNT_W = stlx_pkg::RES_CNT_W;
    localparam int IDX_W = stlx_pkg::RES_IDX_W;

    stlx_pkg::stlx_bundle_t bundle_reg;
    stlx_pkg::stlx_bundle_t bundle_next;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   take;
    logic                   last;

    assign take     = valid_reg && m_tready;
    assign last     = (CNT_W'(idx_reg) + CNT_W'(1)) == bundle_reg.cnt;
    assign q_rd     = q_valid && (!valid_reg || (take && last));
    assign m_tvalid = valid_reg;
    assign m_res    = bundle_reg.res[idx_reg];

    always_comb begin
        bundle_next = bundle_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        if (q_rd) begin
            bundle_next = q_data;
            idx_next    = '0;
            valid_next  = 1'b1;
        end else if (take) begin
            if (last) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bundle_reg <= bundle_next;
    end

    `STLX_ASSERT_IMP(a_idx_in_bundle, aclk, aresetn, valid_reg, CNT_W'(idx_reg) < bundle_reg.cnt, "result index past bundle count")
    `STLX_ASSERT_IMP(a_end_marker_empty, aclk, aresetn, valid_reg && m_res.tend, (m_res.ch == '0) && !m_res.start, "end marker carries a byte or start flag")

endmodule

/* src/script_token_lexer_unit.sv */
// top level of the streaming script token lexer
//
//  channel   | dir | tdata              | tuser
//  ----------+-----+--------------------+--------------------------------------
//  s_ (text) | in  | [7:0] in_char      | [0] end_of_data
//  m_ (tok)  | out | [7:0] out_char     | [2:0] token_kind [3] token_start
//            |     |                    | [4] token_end
//
// one text byte is taken per cycle while the four-entry bundle queue has room
// each byte yields zero to four result transactions, sent one per cycle while
// m_tready is high
// a byte's bundle enters the queue on acceptance, then the back end's output register
// aresetn (synchronous, active low) clears the lexer mode, holds, queue and
// output valid; m_tready low stalls only the back end until the queue fills
module script_token_lexer_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tuser,   // [0] end_of_data
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic [4:0] m_tuser    // [2:0] token_kind, [3] token_start, [4] token_end
);

    // front to queue
    logic                   q_wr;
    stlx_pkg::stlx_bundle_t q_wr_data;
    logic                   q_full;

    // queue to back
    logic                   q_rd;
    logic                   q_valid;
    stlx_pkg::stlx_bundle_t q_rd_data;

    stlx_pkg::stlx_result_t m_res;

    // lexer state and classification, one byte per accepted transaction
    stlx_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .in_char     (s_tdata),
        .end_of_data (s_tuser),
        .q_full      (q_full),
        .q_wr        (q_wr),
        .q_wr_data   (q_wr_data)
    );

    // decouples byte intake from result playout
    stlx_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_wr),
        .wr_data  (q_wr_data),
        .full     (q_full),
        .rd_en    (q_rd),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data)
    );

    // serializes each bundle onto the result channel
    stlx_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_rd_data),
        .q_rd     (q_rd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    // result fields onto the stream buses
    assign m_tdata = m_res.ch;
    assign m_tuser = {m_res.tend, m_res.start, m_res.kind};

endmodule
